FILE: sv/strided_rank_to_grid_index_defines.svh
// Assertion helpers used by the checker file of this block.
`ifndef STRIDED_RANK_TO_GRID_INDEX_DEFINES_SVH
`define STRIDED_RANK_TO_GRID_INDEX_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define SRGI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is asserted.
`define SRGI_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: sv/srgi_pkg.sv
package srgi_pkg;

  // Width of processor numbers, indexes, counts and strides.
  localparam int DataW = 16;
  // Largest number of grid dimensions.
  localparam int NumDims = 3;
  localparam int DimsW = 2;
  localparam int DimIdxW = (NumDims > 1) ? $clog2(NumDims) : 1;
  // Configuration register index width.
  localparam int CfgIdxW = 3;

  // Quotient bits resolved in one pipeline stage.
  localparam int BitsPerStep = 4;
  localparam int StepsPerDim = DataW / BitsPerStep;

  // Pipeline stage map.
  localparam int StageIn = 0;
  localparam int StageBase = 1;
  localparam int StageDiv0 = 2;
  localparam int StageTail = StageDiv0 + NumDims * StepsPerDim;
  localparam int NumStages = StageTail + 2;
  localparam int FillW = $clog2(NumStages + 1);

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    RegNumDims = 'd0,
    RegBaseCpu = 'd1,
    RegCount0  = 'd2,
    RegCount1  = 'd3,
    RegCount2  = 'd4,
    RegStride0 = 'd5,
    RegStride1 = 'd6,
    RegStride2 = 'd7
  } srgi_reg_e;

  // Tables derived from the configuration. A stride of zero skips a position.
  typedef struct packed {
    logic [DataW-1:0]                base;
    logic [NumDims-1:0][DataW-1:0]   stride;
    logic [NumDims-1:0][DataW-1:0]   mult;
  } srgi_tables_t;

  // One item as it moves down the pipeline.
  typedef struct packed {
    logic             below;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] nq;
    logic [DataW-1:0] ndx;
    logic [DataW-1:0] prod;
  } srgi_beat_t;

  // Partial remainder and the shifting dividend/quotient word.
  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] nq;
  } srgi_div_t;

  // A few steps of restoring division. Quotient bits shift in at the bottom
  // of nq while the dividend bits shift out at its top.
  function automatic srgi_div_t div_bits(input logic [DataW-1:0] rem,
                                         input logic [DataW-1:0] nq,
                                         input logic [DataW-1:0] dvs);
    logic [DataW:0] trial;
    srgi_div_t      res;
    res.rem = rem;
    res.nq  = nq;
    for (int b = 0; b < BitsPerStep; b++) begin
      trial  = {res.rem, res.nq[DataW-1]};
      res.nq = {res.nq[DataW-2:0], 1'b0};
      if (trial >= {1'b0, dvs}) begin
        trial     = trial - {1'b0, dvs};
        res.nq[0] = 1'b1;
      end
      res.rem = trial[DataW-1:0];
    end
    return res;
  endfunction

  // Contribution of one position to the index; skipped positions give zero.
  function automatic logic [DataW-1:0] dim_weight(input logic [DataW-1:0] quo,
                                                  input logic [DataW-1:0] stride,
                                                  input logic [DataW-1:0] mult);
    logic [2*DataW-1:0] full;
    full = quo * mult;
    if (stride == '0) begin
      return '0;
    end
    return full[DataW-1:0];
  endfunction

endpackage

FILE: sv/srgi_cfg.sv
module srgi_cfg import srgi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  output srgi_tables_t       tables_o
);

  logic [DimsW-1:0]              num_dims_q;
  logic [DataW-1:0]              base_q;
  logic [NumDims-1:0][DataW-1:0] count_q;
  logic [NumDims-1:0][DataW-1:0] stride_q;

  logic [NumDims-1:0][DataW-1:0] sort_stride_d, sort_stride_q;
  logic [NumDims-1:0][DataW-1:0] sort_mult_d, sort_mult_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_dims_q <= DimsW'(1);
      base_q     <= '0;
      for (int i = 0; i < NumDims; i++) begin
        count_q[i]  <= DataW'(1);
        stride_q[i] <= DataW'(1);
      end
    end else if (cfg_we_i) begin
      case (srgi_reg_e'(cfg_idx_i))
        RegNumDims: num_dims_q  <= cfg_data_i[DimsW-1:0];
        RegBaseCpu: base_q      <= cfg_data_i;
        RegCount0:  count_q[0]  <= cfg_data_i;
        RegCount1:  count_q[1]  <= cfg_data_i;
        RegCount2:  count_q[2]  <= cfg_data_i;
        RegStride0: stride_q[0] <= cfg_data_i;
        RegStride1: stride_q[1] <= cfg_data_i;
        RegStride2: stride_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Rebuild: running products of the counts, then a stable ascending sort
  // by stride. Each used dimension lands at the position given by its rank.
  always_comb begin
    logic [DimsW-1:0]              dims;
    logic [NumDims-1:0]            used;
    logic [NumDims-1:0][DataW-1:0] mult;
    logic [DimIdxW-1:0]            rank [NumDims];
    logic [2*DataW-1:0]            full;

    dims = (num_dims_q == '0) ? DimsW'(1) : num_dims_q;
    if (32'(dims) > NumDims) begin
      dims = DimsW'(NumDims);
    end
    for (int i = 0; i < NumDims; i++) begin
      used[i] = (32'(dims) > i);
    end

    mult[0] = DataW'(1);
    for (int i = 1; i < NumDims; i++) begin
      full    = mult[i-1] * count_q[i-1];
      mult[i] = full[DataW-1:0];
    end

    for (int i = 0; i < NumDims; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NumDims; j++) begin
        if (used[j] && (j < i) && (stride_q[j] <= stride_q[i])) begin
          rank[i] = rank[i] + DimIdxW'(1);
        end
        if (used[j] && (j > i) && (stride_q[j] < stride_q[i])) begin
          rank[i] = rank[i] + DimIdxW'(1);
        end
      end
    end

    for (int p = 0; p < NumDims; p++) begin
      sort_stride_d[p] = '0;
      sort_mult_d[p]   = DataW'(1);
      for (int i = 0; i < NumDims; i++) begin
        if (used[i] && (32'(rank[i]) == p)) begin
          sort_stride_d[p] = stride_q[i];
          sort_mult_d[p]   = mult[i];
        end
      end
    end
  end

  // The sorted tables settle in the cycle after a register write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < NumDims; p++) begin
        sort_stride_q[p] <= (p == 0) ? DataW'(1) : '0;
        sort_mult_q[p]   <= DataW'(1);
      end
    end else begin
      sort_stride_q <= sort_stride_d;
      sort_mult_q   <= sort_mult_d;
    end
  end

  assign tables_o.base   = base_q;
  assign tables_o.stride = sort_stride_q;
  assign tables_o.mult   = sort_mult_q;

endmodule

FILE: sv/strided_rank_to_grid_index.sv
// Strided processor grid index converter.
// Input channel: in_valid_i / in_stall_o carry one cpu_number_i per beat.
// Output channel: out_valid_o / out_stall_i carry grid_index_o and
// below_base_o per beat, one result for each input beat, in order.
// Configuration: a write on cfg_we_i stores cfg_data_i into the register
// named by cfg_idx_i; the sorted stride tables follow in the cycle after.
// Write only while no beats are in flight.
// Pipeline: 16 stages: input capture, base subtract, four 4-bit restoring
// divide stages per dimension, then a final multiply and add.
// Throughput: one beat per cycle unless stalled; dividers fully pipelined.
// Stalls: each stage holds its beat while the next one is full and held,
// so empty stages keep filling while the output is stalled; in_stall_o
// rises only when every stage holds a beat and out_stall_i is high.
// Reset: empties the pipeline and loads one dimension, base 0, all counts
// and strides 1.
module strided_rank_to_grid_index import srgi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [DataW-1:0]   cpu_number_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [DataW-1:0]   grid_index_o,
  output logic               below_base_o
);

  srgi_tables_t           tables;
  logic [NumStages-1:0]   valid_q;
  logic [NumStages-1:0]   enable;
  srgi_beat_t             beat_q [NumStages];

  srgi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tables_o   (tables)
  );

  // A stage takes a new beat when it is empty or its beat moves on.
  always_comb begin
    enable[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      enable[s] = !valid_q[s] || enable[s+1];
    end
  end

  assign in_stall_o = !enable[StageIn];

  // Valid bits travel with the beats.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (enable[StageIn]) begin
        valid_q[StageIn] <= in_valid_i;
      end
      for (int s = 1; s < NumStages; s++) begin
        if (enable[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  for (genvar s = 0; s < NumStages; s++) begin : g_stage
    srgi_beat_t beat_d;

    if (s == StageIn) begin : g_in
      // Capture the processor number.
      always_comb begin
        beat_d    = '0;
        beat_d.nq = cpu_number_i;
      end
    end else if (s == StageBase) begin : g_base
      // Subtract the base; numbers below it divide as zero.
      always_comb begin
        beat_d       = '0;
        beat_d.below = (beat_q[s-1].nq < tables.base);
        beat_d.rem   = beat_d.below ? '0 : (beat_q[s-1].nq - tables.base);
      end
    end else if (s < StageTail) begin : g_div
      localparam int J = s - StageDiv0;
      localparam int Pos = NumDims - 1 - J / StepsPerDim;
      localparam int Sub = J % StepsPerDim;
      localparam bit HasPrev = (Pos + 1 < NumDims);
      localparam int PrevPos = HasPrev ? Pos + 1 : Pos;
      srgi_div_t step;

      // Divide by the stride of this position, largest stride first; the
      // previous quotient is weighted and accumulated alongside.
      always_comb begin
        beat_d = beat_q[s-1];
        if (Sub == 0) begin
          step = div_bits('0, beat_q[s-1].rem, tables.stride[Pos]);
        end else begin
          step = div_bits(beat_q[s-1].rem, beat_q[s-1].nq, tables.stride[Pos]);
        end
        beat_d.rem = step.rem;
        beat_d.nq  = step.nq;
        if (HasPrev && (Sub == 0)) begin
          beat_d.prod = dim_weight(beat_q[s-1].nq, tables.stride[PrevPos],
                                   tables.mult[PrevPos]);
        end
        if (HasPrev && (Sub == 1)) begin
          beat_d.ndx = beat_q[s-1].ndx + beat_q[s-1].prod;
        end
      end
    end else if (s == StageTail) begin : g_tail_mul
      // Weight the quotient of the smallest stride.
      always_comb begin
        beat_d      = beat_q[s-1];
        beat_d.prod = dim_weight(beat_q[s-1].nq, tables.stride[0], tables.mult[0]);
      end
    end else begin : g_tail_add
      // Final accumulate into the output register.
      always_comb begin
        beat_d     = beat_q[s-1];
        beat_d.ndx = beat_q[s-1].ndx + beat_q[s-1].prod;
      end
    end

    always_ff @(posedge clk_i) begin
      if (enable[s]) begin
        beat_q[s] <= beat_d;
      end
    end
  end

  assign out_valid_o  = valid_q[NumStages-1];
  assign grid_index_o = beat_q[NumStages-1].ndx;
  assign below_base_o = beat_q[NumStages-1].below;

endmodule

FILE: sv/srgi_checker.sv
`include "strided_rank_to_grid_index_defines.svh"

module srgi_checker import srgi_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [DataW-1:0]   grid_index_o,
  input logic               below_base_o
);

  logic [FillW-1:0] inflight_d, inflight_q;
  logic             in_beat, out_beat;

  // Count beats taken in but not yet delivered.
  assign in_beat  = in_valid_i && !in_stall_o;
  assign out_beat = out_valid_o && !out_stall_i;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + FillW'(1);
    end else if (out_beat && !in_beat) begin
      inflight_d = inflight_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  // A result never appears without a beat in flight, and no more beats
  // than stages are ever held.
  `SRGI_ASSERT(a_no_invented_result, out_valid_o |-> (inflight_q != '0),
               "result without an accepted input beat")
  `SRGI_ASSERT(a_fill_bounded, inflight_q <= FillW'(NumStages),
               "more beats in flight than pipeline stages")
  // The input side only backs up when the output is full and stalled.
  `SRGI_ASSERT_ALWAYS(a_stall_only_when_full,
                      in_stall_o |-> (out_valid_o && out_stall_i),
                      "input stalled while the output is free")
  // A flagged number always reports index zero; a stalled result holds.
  `SRGI_ASSERT(a_below_zero_hold,
               (out_valid_o && below_base_o) |-> (grid_index_o == '0),
               "below-base result with nonzero index")
  `SRGI_ASSERT(a_stalled_result_holds,
               (out_valid_o && out_stall_i) |=>
                 (out_valid_o && $stable(grid_index_o) && $stable(below_base_o)),
               "stalled result changed")

endmodule

bind strided_rank_to_grid_index srgi_checker u_srgi_checker (.*);

FILE: sim/strided_rank_to_grid_index_tb.sv
`timescale 1ns / 100ps

module strided_rank_to_grid_index_tb;
  import srgi_pkg::*;

  localparam int IdleLimit  = 5000;
  localparam int HoldCycles = 80;
  localparam int DrainWait  = 30;

  typedef struct packed {
    logic [DataW-1:0] grid_index;
    logic             below_base;
  } grid_result_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               cfg_we_i     = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i    = RegNumDims;
  logic [DataW-1:0]   cfg_data_i   = '0;
  logic               in_valid_i   = 1'b0;
  logic               in_stall_o;
  logic [DataW-1:0]   cpu_number_i = '0;
  logic               out_valid_o;
  logic               out_stall_i  = 1'b0;
  logic [DataW-1:0]   grid_index_o;
  logic               below_base_o;

  strided_rank_to_grid_index dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cpu_number_i (cpu_number_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .grid_index_o (grid_index_o),
    .below_base_o (below_base_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the configuration registers and the derived tables.
  logic [1:0]       grid_dims;
  logic [DataW-1:0] grid_base;
  logic [DataW-1:0] grid_count  [NumDims];
  logic [DataW-1:0] grid_stride [NumDims];
  logic [DataW-1:0] sorted_stride [NumDims];
  logic [DataW-1:0] sorted_mult   [NumDims];

  grid_result_t expected_grid[$];

  int  fail_count   = 0;
  int  items_sent   = 0;
  int  results_seen = 0;
  int  grids_loaded = 0;
  int  idle_cycles  = 0;
  int  hold_left    = 0;
  bit  hold_request = 1'b0;
  bit  tx_idle_on   = 1'b1;
  bit  rx_idle_on   = 1'b1;
  int  grid_span    = 1;

  // Zero and oversized dimension counts are clamped into the legal range.
  function automatic int dims_used();
    int d;
    d = grid_dims;
    if (d == 0) d = 1;
    if (d > NumDims) d = NumDims;
    return d;
  endfunction

  // Multipliers are running products of the counts; then a stable sort by stride.
  function void rebuild_tables();
    logic [DataW-1:0] prod;
    logic [DataW-1:0] s;
    logic [DataW-1:0] m;
    int               d;
    int               j;
    d    = dims_used();
    prod = 1;
    for (int i = 0; i < NumDims; i++) begin
      sorted_stride[i] = 1;
      sorted_mult[i]   = 1;
    end
    for (int i = 0; i < d; i++) begin
      sorted_mult[i]   = prod;
      sorted_stride[i] = grid_stride[i];
      prod             = prod * grid_count[i];
    end
    for (int i = 1; i < d; i++) begin
      s = sorted_stride[i];
      m = sorted_mult[i];
      j = i;
      while (j > 0 && sorted_stride[j-1] > s) begin
        sorted_stride[j] = sorted_stride[j-1];
        sorted_mult[j]   = sorted_mult[j-1];
        j--;
      end
      sorted_stride[j] = s;
      sorted_mult[j]   = m;
    end
  endfunction

  // Mixed-radix conversion: divide by the largest stride first, carry the remainder.
  function automatic grid_result_t predict_grid(logic [DataW-1:0] cpu);
    grid_result_t     res;
    logic [DataW-1:0] rem;
    logic [DataW-1:0] q;
    logic [DataW-1:0] ndx;
    res = '0;
    if (cpu < grid_base) begin
      res.below_base = 1'b1;
      return res;
    end
    rem = cpu - grid_base;
    ndx = '0;
    for (int k = dims_used(); k > 0; k--) begin
      if (sorted_stride[k-1] != '0) begin
        q   = rem / sorted_stride[k-1];
        rem = rem - q * sorted_stride[k-1];
        ndx = ndx + q * sorted_mult[k-1];
      end
    end
    res.grid_index = ndx;
    return res;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Write one register while the pipeline is empty and mirror it in the shadow copy.
  task automatic write_reg(srgi_reg_e idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      RegNumDims: grid_dims      = val[1:0];
      RegBaseCpu: grid_base      = val;
      RegCount0:  grid_count[0]  = val;
      RegCount1:  grid_count[1]  = val;
      RegCount2:  grid_count[2]  = val;
      RegStride0: grid_stride[0] = val;
      RegStride1: grid_stride[1] = val;
      RegStride2: grid_stride[2] = val;
      default: ;
    endcase
    rebuild_tables();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stop offering beats and wait until every expected result is back.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_grid.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_grid(logic [DataW-1:0] dims, logic [DataW-1:0] base,
                          logic [DataW-1:0] c0, logic [DataW-1:0] c1, logic [DataW-1:0] c2,
                          logic [DataW-1:0] s0, logic [DataW-1:0] s1, logic [DataW-1:0] s2);
    wait_idle();
    write_reg(RegNumDims, dims);
    write_reg(RegBaseCpu, base);
    write_reg(RegCount0, c0);
    write_reg(RegCount1, c1);
    write_reg(RegCount2, c2);
    write_reg(RegStride0, s0);
    write_reg(RegStride1, s1);
    write_reg(RegStride2, s2);
    grids_loaded++;
    // The sorted tables settle in the cycle after the last write.
    repeat (2) @(posedge clk_i);
  endtask

  // Offer one beat, with an optional random gap first, and record its result.
  task automatic send_cpu(logic [DataW-1:0] cpu);
    int gap;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 9) < 3) begin
      gap = gap_len();
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cpu_number_i <= cpu;
    do @(posedge clk_i); while (in_stall_o);
    expected_grid.push_back(predict_grid(cpu));
    items_sent++;
  endtask

  // Pick a number inside the grid most of the time, with some outside and below it.
  function automatic logic [DataW-1:0] pick_cpu();
    int r;
    int top;
    r = $urandom_range(0, 9);
    if (r == 0 && grid_base > 0) return 16'($urandom_range(0, grid_base - 1));
    if (r <= 2) return 16'($urandom);
    top = 65535 - grid_base;
    if (grid_span - 1 < top) top = grid_span - 1;
    return 16'(grid_base + $urandom_range(0, top));
  endfunction

  // Random grid: mostly strides that are products of the counts in a shuffled order.
  task automatic random_grid();
    logic [DataW-1:0] c [NumDims];
    logic [DataW-1:0] s [NumDims];
    logic [DataW-1:0] run;
    logic [DataW-1:0] dims;
    logic [DataW-1:0] base;
    int               p [NumDims];
    int               j;
    int               tmp;
    longint           span;
    for (int i = 0; i < NumDims; i++) begin
      p[i] = i;
      case ($urandom_range(0, 11))
        0:       c[i] = 16'($urandom);
        1:       c[i] = 0;
        default: c[i] = 16'($urandom_range(1, 12));
      endcase
    end
    for (int i = NumDims - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      tmp  = p[i];
      p[i] = p[j];
      p[j] = tmp;
    end
    run  = 16'($urandom_range(1, 3));
    span = run;
    for (int o = 0; o < NumDims; o++) begin
      s[p[o]] = run;
      run     = run * c[p[o]];
      span    = span * ((c[p[o]] == 0) ? 1 : c[p[o]]);
      if (span > 65536) span = 65536;
    end
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < NumDims; i++) s[i] = 16'($urandom);
    end
    if ($urandom_range(0, 7) == 0) s[$urandom_range(0, NumDims - 1)] = 0;
    dims      = {14'($urandom_range(0, 16383)), 2'($urandom_range(0, 3))};
    base      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 200));
    grid_span = int'(span);
    set_grid(dims, base, c[0], c[1], c[2], s[0], s[1], s[2]);
  endtask

  // Tables straight out of reset: the index equals the number.
  task automatic test_reset_tables();
    send_cpu(16'h0000);
    send_cpu(16'hFFFF);
    send_cpu(16'h5A5A);
  endtask

  // Hand-picked grids for the corner cases of the conversion.
  task automatic test_corner_grids();
    // A regular three-dimensional grid, including numbers below and past it.
    set_grid(3, 100, 4, 3, 2, 1, 4, 12);
    send_cpu(99);
    send_cpu(100);
    send_cpu(123);
    send_cpu(16'hFFFF);
    // Zero dimension count with junk upper bits behaves as one dimension.
    set_grid(16'hFFFC, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7, 7, 7);
    send_cpu(16'hFFFF);
    send_cpu(6);
    send_cpu(7);
    // Equal strides keep their dimension order.
    set_grid(16'h0003, 0, 3, 3, 3, 5, 5, 5);
    send_cpu(0);
    send_cpu(4);
    send_cpu(5);
    send_cpu(14);
    send_cpu(44);
    // A zero stride is skipped and a zero count clears the later multipliers.
    set_grid(3, 0, 0, 7, 9, 2, 0, 30);
    send_cpu(1);
    send_cpu(31);
    send_cpu(65);
    send_cpu(1000);
    // Maximal counts wrap the multipliers; largest base.
    set_grid(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3, 1, 2);
    send_cpu(16'hFFFF);
    send_cpu(16'hFFFE);
    // Two dimensions with the largest stride.
    set_grid(2, 0, 256, 256, 1, 16'hFFFF, 1, 16'hFFFF);
    send_cpu(16'hFFFF);
    send_cpu(16'hFFFE);
  endtask

  // Random grids, each with a batch of numbers; idling toggles per grid.
  task automatic test_random_grids();
    for (int g = 0; g < 10; g++) begin
      random_grid();
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 32; n++) send_cpu(pick_cpu());
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Long output hold fills the pipeline; then the sender pauses until it drains.
  task automatic test_backpressure();
    random_grid();
    tx_idle_on   = 1'b0;
    hold_request = 1'b1;
    for (int n = 0; n < 40; n++) send_cpu(pick_cpu());
    wait_idle();
    tx_idle_on = 1'b1;
    for (int n = 0; n < 20; n++) send_cpu(pick_cpu());
  endtask

  // Output side: random stalls, plus a long hold on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_request) begin
        hold_left    = HoldCycles;
        hold_request = 1'b0;
      end
      if (hold_left == 0 && rx_idle_on && $urandom_range(0, 99) < 25) hold_left = gap_len();
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each result beat with the oldest expectation.
  always @(posedge clk_i) begin : check_results
    grid_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_grid.size() == 0) begin
        $error("unexpected result beat: grid_index %0d below_base %0b",
               grid_index_o, below_base_o);
        fail_count++;
      end else begin
        want = expected_grid.pop_front();
        results_seen++;
        if (grid_index_o !== want.grid_index) begin
          $error("grid_index mismatch: expected %0d, actual %0d", want.grid_index, grid_index_o);
          fail_count++;
        end
        if (below_base_o !== want.below_base) begin
          $error("below_base mismatch: expected %0b, actual %0b", want.below_base, below_base_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles without any accepted beat or register write.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout after %0d cycles with no progress", IdleLimit);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    grid_dims = 1;
    grid_base = '0;
    for (int i = 0; i < NumDims; i++) begin
      grid_count[i]  = 1;
      grid_stride[i] = 1;
    end
    rebuild_tables();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_tables();
    test_corner_grids();
    test_random_grids();
    test_backpressure();

    wait_idle();
    repeat (DrainWait) @(posedge clk_i);
    if (expected_grid.size() != 0) begin
      $error("%0d expected results never arrived", expected_grid.size());
      fail_count++;
    end
    $display("Converted %0d processor numbers over %0d grid settings, %0d results checked,",
             items_sent, grids_loaded, results_seen);
    $display("with random stalls on both sides and one long output hold.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
